// ----- rtl/iegcd_pkg.sv -----
`timescale 1ns / 1ps

package iegcd_pkg;

    // Sequencer state encoding.
    typedef logic [1:0] state_t;

    localparam state_t ST_IDLE  = 2'd0;
    localparam state_t ST_CHECK = 2'd1;
    localparam state_t ST_DIV   = 2'd2;
    localparam state_t ST_UPD   = 2'd3;

endpackage

// ----- rtl/integer_extended_gcd_core.sv -----
`timescale 1ns / 1ps

// Extended Euclid core: a beat is accepted when start is high and busy is low. The core
// then runs Euclid's remainder loop on the operand magnitudes and returns the gcd
// and the sign-adjusted Bezout coefficients on divisor, coef_a and coef_b, valid
// for exactly one cycle while done is high; the receiver cannot stall, so it must
// take the beat in that cycle. An item keeps busy high through k Euclid iterations
// and a final zero check, where k is zero when b_value is zero and at most
// about 1.44*(WIDTH-1). Each iteration costs one zero check, WIDTH-1 steps of a
// one-bit-per-cycle restoring divider that also builds the products q*x and q*y
// by shift-and-add, and one coefficient update. A new beat may be accepted in
// the same cycle that done is shown.
module integer_extended_gcd_core #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [WIDTH-1:0] a_value,
    input  logic signed [WIDTH-1:0] b_value,
    output logic                    done,
    output logic        [WIDTH-2:0] divisor,
    output logic signed [WIDTH-1:0] coef_a,
    output logic signed [WIDTH-1:0] coef_b
);

    import iegcd_pkg::*;

    localparam int MW = WIDTH - 1;
    localparam int CW = $clog2(MW);
    localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {MW{1'b0}}};
    localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {MW{1'b1}}};
    localparam logic [CW-1:0]    LAST_STEP = CW'(MW - 1);

    state_t            state_reg;
    logic [CW-1:0]     cnt_reg;
    logic              done_reg;
    logic [MW-1:0]     ra_reg;
    logic [MW-1:0]     rb_reg;
    logic [MW-1:0]     rem_reg;
    logic [MW-1:0]     dvd_reg;
    logic [WIDTH-1:0]  px_reg;
    logic [WIDTH-1:0]  cx_reg;
    logic [WIDTH-1:0]  py_reg;
    logic [WIDTH-1:0]  cy_reg;
    logic [WIDTH-1:0]  accx_reg;
    logic [WIDTH-1:0]  accy_reg;
    logic [WIDTH-1:0]  a_reg;
    logic [WIDTH-1:0]  b_reg;
    logic [MW-1:0]     div_reg;
    logic [WIDTH-1:0]  coefa_reg;
    logic [WIDTH-1:0]  coefb_reg;

    logic [MW-1:0]     abs_a;
    logic [MW-1:0]     abs_b;
    logic [MW:0]       trial;
    logic [MW+1:0]     diff;
    logic              qbit;
    logic [WIDTH-1:0]  accx_next;
    logic [WIDTH-1:0]  accy_next;
    logic [WIDTH-1:0]  sgn_a;
    logic [WIDTH-1:0]  sgn_b;

    // Saturating magnitude of a two's complement operand.
    function automatic logic [MW-1:0] sat_abs(input logic [WIDTH-1:0] v);
        logic [WIDTH-1:0] neg;
        neg = -v;
        if (!v[WIDTH-1])
        begin
            sat_abs = v[MW-1:0];
        end
        else if (v == MIN_VAL)
        begin
            sat_abs = MAX_POS[MW-1:0];
        end
        else
        begin
            sat_abs = neg[MW-1:0];
        end
    endfunction

    // Coefficient times the sign of its operand, saturating on negation.
    function automatic logic [WIDTH-1:0] apply_sign(input logic [WIDTH-1:0] c,
                                                    input logic [WIDTH-1:0] s);
        if (s == '0)
        begin
            apply_sign = '0;
        end
        else if (!s[WIDTH-1])
        begin
            apply_sign = c;
        end
        else if (c == MIN_VAL)
        begin
            apply_sign = MAX_POS;
        end
        else
        begin
            apply_sign = -c;
        end
    endfunction

    assign abs_a = sat_abs(a_value);
    assign abs_b = sat_abs(b_value);

    // One restoring division step, with shift-and-add of the quotient bit into
    // the two coefficient products.
    assign trial     = {rem_reg, dvd_reg[MW-1]};
    assign diff      = {1'b0, trial} - {2'b00, rb_reg};
    assign qbit      = !diff[MW+1];
    assign accx_next = {accx_reg[WIDTH-2:0], 1'b0} + (qbit ? cx_reg : '0);
    assign accy_next = {accy_reg[WIDTH-2:0], 1'b0} + (qbit ? cy_reg : '0);

    // Final sign adjustment of the coefficients.
    assign sgn_a = apply_sign(px_reg, a_reg);
    assign sgn_b = apply_sign(py_reg, b_reg);

    // Sequencer and datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_CHECK) && (rb_reg == '0);
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        a_reg     <= a_value;
                        b_reg     <= b_value;
                        ra_reg    <= abs_a;
                        rb_reg    <= abs_b;
                        px_reg    <= WIDTH'(1);
                        cx_reg    <= '0;
                        py_reg    <= '0;
                        cy_reg    <= WIDTH'(1);
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    if (rb_reg == '0)
                    begin
                        div_reg   <= ra_reg;
                        coefa_reg <= sgn_a;
                        coefb_reg <= sgn_b;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        rem_reg   <= '0;
                        dvd_reg   <= ra_reg;
                        accx_reg  <= '0;
                        accy_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg  <= qbit ? diff[MW-1:0] : trial[MW-1:0];
                    dvd_reg  <= {dvd_reg[MW-2:0], 1'b0};
                    accx_reg <= accx_next;
                    accy_reg <= accy_next;
                    cnt_reg  <= cnt_reg + CW'(1);
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    ra_reg    <= rb_reg;
                    rb_reg    <= rem_reg;
                    px_reg    <= cx_reg;
                    cx_reg    <= px_reg - accx_reg;
                    py_reg    <= cy_reg;
                    cy_reg    <= py_reg - accy_reg;
                    state_reg <= ST_CHECK;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign divisor = div_reg;
    assign coef_a  = coefa_reg;
    assign coef_b  = coefb_reg;

endmodule

// ----- rtl/iegcd_checker.sv -----
`timescale 1ns / 1ps

module iegcd_checker #(
    parameter int WIDTH = 32
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    done,
    input logic        [WIDTH-2:0] divisor,
    input logic signed [WIDTH-1:0] coef_a,
    input logic signed [WIDTH-1:0] coef_b
);

    // An accepted beat puts the core to work.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after accepting a beat");

    // A result only follows a period of work.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("result shown without preceding work");

    // The core only goes idle when it delivers its result.
    a_idle_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("core went idle without a result");

    // A zero gcd means both operands were zero, so both coefficients are zero.
    a_zero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (divisor == '0)) |-> ((coef_a == '0) && (coef_b == '0)))
        else $error("nonzero coefficient with zero gcd");

endmodule

bind integer_extended_gcd_core iegcd_checker #(.WIDTH(WIDTH)) u_iegcd_checker (.*);

// ----- sim/tb_integer_extended_gcd_core.sv -----
`timescale 1ns / 1ps

module tb_integer_extended_gcd_core;

    localparam int W = 32;
    localparam int CLK_HALF = 10;
    localparam int RANDOM_BEATS = 550;
    // The longest Euclid chain at 32 bits takes about 46 iterations per beat, and the
    // limit allows every beat to take that long, several times over.
    localparam longint CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 2 * (W + 1) + 8;

    localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-2:0] MAX_GCD = {(W-1){1'b1}};

    typedef struct {
        logic [W-2:0]        divisor;
        logic signed [W-1:0] coef_a;
        logic signed [W-1:0] coef_b;
    } bezout_t;

    typedef struct {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        bit                  known;
        bezout_t             result;
    } operand_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic signed [W-1:0] a_value = '0;
    logic signed [W-1:0] b_value = '0;
    logic                busy;
    logic                done;
    logic [W-2:0]        divisor;
    logic signed [W-1:0] coef_a;
    logic signed [W-1:0] coef_b;

    bezout_t      pending_bezout[$];
    int           mismatch_count = 0;
    int           idle_pct = 6;
    longint       cycle_count = 0;
    operand_row_t directed_rows[22];

    integer_extended_gcd_core #(
        .WIDTH(W)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .a_value(a_value),
        .b_value(b_value),
        .done(done),
        .divisor(divisor),
        .coef_a(coef_a),
        .coef_b(coef_b)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL integer_extended_gcd_core");
            $finish;
        end
    end

    // Magnitude of a two's complement value; the most negative value saturates.
    function automatic logic [W-1:0] magnitude_sat(input logic [W-1:0] v);
        if (!v[W-1])
            return v;
        if (v == MOST_NEG)
            return MOST_POS;
        return -v;
    endfunction

    // Coefficient times the sign of its operand, saturating on negation.
    function automatic logic [W-1:0] sign_adjust(input logic [W-1:0] c, input logic [W-1:0] s);
        if (s == '0)
            return '0;
        if (!s[W-1])
            return c;
        if (c == MOST_NEG)
            return MOST_POS;
        return -c;
    endfunction

    // Euclid's remainder loop on the magnitudes with both coefficient recurrences.
    // All coefficient arithmetic wraps at the operand width.
    function automatic bezout_t predict_bezout(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W-1:0] rem_hi;
        logic [W-1:0] rem_lo;
        logic [W-1:0] quot;
        logic [W-1:0] rem_next;
        logic [W-1:0] x_cur;
        logic [W-1:0] x_prev;
        logic [W-1:0] y_cur;
        logic [W-1:0] y_prev;
        logic [W-1:0] coef_next;
        bezout_t      res;
        rem_hi = magnitude_sat(a);
        rem_lo = magnitude_sat(b);
        x_cur = '0;
        x_prev = 1;
        y_cur = 1;
        y_prev = '0;
        while (rem_lo != '0)
        begin
            quot = rem_hi / rem_lo;
            rem_next = rem_hi % rem_lo;
            rem_hi = rem_lo;
            rem_lo = rem_next;
            coef_next = x_prev - quot * x_cur;
            x_prev = x_cur;
            x_cur = coef_next;
            coef_next = y_prev - quot * y_cur;
            y_prev = y_cur;
            y_cur = coef_next;
        end
        res.divisor = rem_hi[W-2:0];
        res.coef_a = sign_adjust(x_prev, a);
        res.coef_b = sign_adjust(y_prev, b);
        return res;
    endfunction

    // Offer one operand beat, idling at random, and record its result once accepted.
    task automatic send_operands(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                                 input bezout_t want);
        bit accepted;
        accepted = 1'b0;
        while (!accepted)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                start <= 1'b0;
            end
            else
            begin
                start <= 1'b1;
                a_value <= a;
                b_value <= b;
            end
            @(posedge clk);
            accepted = start && !busy;
        end
        pending_bezout.push_back(want);
    endtask

    // Hold off new beats until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_bezout.size() != 0);
    endtask

    function automatic logic signed [W-1:0] random_sign(input logic signed [W-1:0] v);
        return ($urandom_range(1) != 0) ? -v : v;
    endfunction

    function automatic logic signed [W-1:0] edge_operand();
        case ($urandom_range(5))
            0: return '0;
            1: return 1;
            2: return -1;
            3: return MOST_NEG;
            4: return MOST_POS;
            default: return $urandom;
        endcase
    endfunction

    // Random operand pairs: mostly pairs with structure, some raw noise.
    task automatic random_operands(output logic signed [W-1:0] a, output logic signed [W-1:0] b);
        int           mix;
        int           steps;
        logic [W-1:0] fib_hi;
        logic [W-1:0] fib_lo;
        logic [W-1:0] fib_next;
        logic [W-1:0] factor;
        mix = $urandom_range(99);
        if (mix < 35)
        begin
            a = $urandom;
            b = $urandom;
        end
        else if (mix < 55)
        begin
            a = random_sign($urandom_range(1000));
            b = random_sign($urandom_range(1000));
        end
        else if (mix < 75)
        begin
            factor = $urandom_range(1, 5000);
            a = random_sign(factor * $urandom_range(60000));
            b = random_sign(factor * $urandom_range(60000));
        end
        else if (mix < 83)
        begin
            a = edge_operand();
            b = edge_operand();
        end
        else if (mix < 88)
        begin
            // Consecutive Fibonacci numbers give the longest Euclid chains.
            steps = $urandom_range(10, 45);
            fib_hi = 1;
            fib_lo = 1;
            for (int i = 0; i < steps; i++)
            begin
                fib_next = fib_hi + fib_lo;
                fib_lo = fib_hi;
                fib_hi = fib_next;
            end
            a = random_sign(fib_hi);
            b = random_sign(fib_lo);
        end
        else
        begin
            a = $urandom;
            b = random_sign($urandom_range(50));
            if ($urandom_range(1) != 0)
            begin
                b = a;
                a = random_sign($urandom_range(50));
            end
        end
    endtask

    // Result checker: every done beat is matched against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        bezout_t want;
        if (rst_n && done)
        begin
            if (pending_bezout.size() == 0)
            begin
                $error("unexpected result beat: divisor=%0d coef_a=%0d coef_b=%0d",
                       divisor, coef_a, coef_b);
                mismatch_count++;
            end
            else
            begin
                want = pending_bezout.pop_front();
                if (divisor !== want.divisor)
                begin
                    $error("divisor: expected %0d, got %0d", want.divisor, divisor);
                    mismatch_count++;
                end
                if (coef_a !== want.coef_a)
                begin
                    $error("coef_a: expected %0d, got %0d", want.coef_a, coef_a);
                    mismatch_count++;
                end
                if (coef_b !== want.coef_b)
                begin
                    $error("coef_b: expected %0d, got %0d", want.coef_b, coef_b);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin : stimulus
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        bezout_t             want;

        // Known answers for zeros and extremes; the rest go through the predictor.
        directed_rows = '{
            '{32'sd0, 32'sd0, 1'b1, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sd5, 32'sd0, 1'b1, '{31'd5, 32'sd1, 32'sd0}},
            '{-32'sd7, 32'sd0, 1'b1, '{31'd7, -32'sd1, 32'sd0}},
            '{MOST_NEG, 32'sd0, 1'b1, '{MAX_GCD, -32'sd1, 32'sd0}},
            '{MOST_POS, 32'sd0, 1'b1, '{MAX_GCD, 32'sd1, 32'sd0}},
            '{32'sd0, 32'sd5, 1'b1, '{31'd5, 32'sd0, 32'sd1}},
            '{32'sd0, -32'sd5, 1'b1, '{31'd5, 32'sd0, -32'sd1}},
            '{32'sd0, MOST_NEG, 1'b1, '{MAX_GCD, 32'sd0, -32'sd1}},
            '{MOST_NEG, MOST_NEG, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{MOST_POS, MOST_POS, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{MOST_NEG, MOST_POS, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{MOST_POS, -32'sd1, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{-32'sd1, -32'sd1, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sd1, 32'sd1, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sd1836311903, 32'sd1134903170, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{-32'sd1836311903, 32'sd1134903170, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sd240, 32'sd46, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{-32'sd240, -32'sd46, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sd12, -32'sd18, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sd1, MOST_NEG, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{MOST_NEG, 32'sd1, 1'b0, '{31'd0, 32'sd0, 32'sd0}},
            '{32'sh55555555, 32'shAAAAAAAA, 1'b0, '{31'd0, 32'sd0, 32'sd0}}
        };

        // Hold reset, then release it on a clock edge.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with light sender idling.
        idle_pct = 6;
        foreach (directed_rows[i])
        begin
            want = directed_rows[i].known ? directed_rows[i].result
                                          : predict_bezout(directed_rows[i].a,
                                                           directed_rows[i].b);
            send_operands(directed_rows[i].a, directed_rows[i].b, want);
        end
        drain_results();

        // Random beats in three idling phases: light, heavy, none.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
            for (int n = 0; n < RANDOM_BEATS / 3; n++)
            begin
                random_operands(a, b);
                send_operands(a, b, predict_bezout(a, b));
                if ($urandom_range(99) < 2)
                begin
                    drain_results();
                end
            end
            drain_results();
        end

        // Let any stray result beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS integer_extended_gcd_core");
        end
        else
        begin
            $display("FAIL integer_extended_gcd_core");
        end
        $finish;
    end

endmodule
